@@ sv/tlpm_pkg.sv @@
// Shared types and constants for the tank level and pump monitor.
`default_nettype none
package tlpm_pkg;

	localparam int unsigned REG_W      = 16;
	localparam int unsigned APB_AW     = 4;
	localparam int unsigned APB_DW     = 32;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned TICK_W     = 8;
	localparam int unsigned MEAS_W     = 19;
	localparam int unsigned VOL_W      = 26;
	localparam int unsigned FLOW_W     = 24;
	localparam int unsigned OUT_DATA_W = 112;

	localparam int unsigned DIV_NUM_W = 48;
	localparam int unsigned DIV_DEN_W = 36;
	localparam int unsigned DIV_CNT_W = 6;

	localparam logic [DIV_CNT_W-1:0] FLOW_STEPS = 6'd48;

	localparam logic [TICK_W-1:0] FAULT_CHECK_TICKS = 8'd10;

	localparam logic [REG_W-1:0] TANK_HEIGHT_RST = 16'd21760;
	localparam logic [REG_W-1:0] CYL_RADIUS_RST  = 16'd4608;
	localparam logic [REG_W-1:0] UPPER_LIMIT_RST = 16'd21760;
	localparam logic [REG_W-1:0] LOWER_LIMIT_RST = 16'd4352;

	localparam logic [31:0] PI_Q28      = 32'd843314857;
	localparam logic [31:0] FLOW_SCALE  = 32'd2000000000;
	localparam logic [31:0] FLOW_DIV    = 32'd15;
	localparam logic [27:0] MEAS_ROUND  = 28'd291;
	// ceil(2^38 / 582), exact quotient for numerators below 2^28
	localparam logic [31:0] MEAS_RECIP  = 32'd472298810;
	localparam logic [58:0] VOL_ROUND   = 59'h0_8000_0000;

	typedef enum logic [1:0] {
		REG_TANK_HEIGHT = 2'd0,
		REG_CYL_RADIUS  = 2'd1,
		REG_UPPER_LIMIT = 2'd2,
		REG_LOWER_LIMIT = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		REQ_ECHO_RISE = 2'd0,
		REQ_ECHO_FALL = 2'd1,
		REQ_PULSE     = 2'd2,
		REQ_TICK      = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		FAULT_NONE    = 2'd0,
		FAULT_OFF_FLOW = 2'd1,
		FAULT_ON_DRY  = 2'd2,
		FAULT_RSVD    = 2'd3
	} fault_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAS,
		ST_RR,
		ST_RRH,
		ST_VHI,
		ST_VLO,
		ST_VSUM,
		ST_FNUM,
		ST_FDEN,
		ST_FDIV,
		ST_FWAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] steps;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

endpackage
`default_nettype wire

@@ sv/tank_level_pump_monitor.sv @@
// Tank level and pump monitor top level: event bookkeeping, tick sequencer and ports.
`default_nettype none
// Echo edges, flow pulses and second ticks enter on the slave stream, one per
// transfer; only a tick yields a result. Echo and pulse events leave s_tready high.
// A tick runs through one shared 32x32 multiplier and one bit-serial divider:
// nine sequencer steps for the level (a multiply by a reciprocal), the volume
// and the flow operands, then the flow division (skipped when no time has
// elapsed since the previous tick) and the handover of the result. s_tready
// stays low from a tick transfer until that handover, which waits for the
// output register to free. The result waits in an output register, and the
// next events are taken while it waits.
module tank_level_pump_monitor (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [tlpm_pkg::APB_AW-1:0]        paddr,
	input  wire logic [tlpm_pkg::APB_DW-1:0]        pwdata,
	output logic [tlpm_pkg::APB_DW-1:0]             prdata,
	output logic                                    pready,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// time_us [31:0]
	input  wire logic [31:0]                        s_tdata,
	// req_type [1:0]
	input  wire logic [1:0]                         s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// pulse_width_us [15:0], surface_depth [34:16], height_remaining [50:35],
	// volume_ml [76:51], flow_rate [100:77], pump_on [101], buzzer_on [102],
	// fault_code [104:103], fault_checked [105], zero [111:106]
	output logic [tlpm_pkg::OUT_DATA_W-1:0]         m_tdata
);
	import tlpm_pkg::*;

	logic [REG_W-1:0]  tank_height_q, cyl_radius_q, upper_limit_q, lower_limit_q;
	logic [TIME_W-1:0] echo_start_q, interval_start_q, elapsed_q;
	logic [REG_W-1:0]  echo_width_q, pulse_count_q, pc_q;
	logic              interval_started_q, pump_q, buzzer_q;
	logic [TICK_W-1:0] tick_count_q;
	fault_t            fault_q;

	state_t            state_q, state_nx;
	logic [63:0]       prod_q;
	logic [31:0]       mul_a, mul_b;
	logic              mul_en;
	logic [MEAS_W-1:0] meas_q;
	logic [REG_W-1:0]  rem_q;
	logic [19:0]       vlo_q;
	logic [57:0]       a_q;
	logic [VOL_W-1:0]  vol_q;
	logic [FLOW_W-1:0] flow_q;
	logic [DIV_NUM_W-1:0] num_q;

	div_req_t             div_req;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;

	logic              out_valid_q;
	logic [REG_W-1:0]  out_pulse_q, out_rem_q;
	logic [MEAS_W-1:0] out_meas_q;
	logic [VOL_W-1:0]  out_vol_q;
	logic [FLOW_W-1:0] out_flow_q;
	logic              out_pump_q, out_buzzer_q, out_checked_q;
	fault_t            out_fault_q;

	logic              cfg_wr, in_xfer, commit, flowing, check;
	req_t              req;
	logic [TIME_W-1:0] echo_d;
	logic [27:0]       meas_num;
	logic [MEAS_W-1:0] meas_div;
	logic [58:0]       vol_sum;
	logic              pump_nx, buzzer_nx;
	logic [TICK_W-1:0] tick_nx;
	fault_t            fault_nx;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign req      = req_t'(s_tuser);
	assign echo_d   = s_tdata - echo_start_q;
	assign meas_num = {1'b0, echo_width_q, 11'b0} + {3'b0, echo_width_q, 9'b0} + MEAS_ROUND;
	assign meas_div = prod_q[56:38];
	assign vol_sum  = {1'b0, a_q} + VOL_ROUND + {29'b0, prod_q[49:20]};
	assign flowing  = (pc_q != '0) && (elapsed_q != '0);
	assign commit   = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_TANK_HEIGHT: prdata = {16'b0, tank_height_q};
			REG_CYL_RADIUS:  prdata = {16'b0, cyl_radius_q};
			REG_UPPER_LIMIT: prdata = {16'b0, upper_limit_q};
			REG_LOWER_LIMIT: prdata = {16'b0, lower_limit_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tank_height_q <= TANK_HEIGHT_RST;
			cyl_radius_q  <= CYL_RADIUS_RST;
			upper_limit_q <= UPPER_LIMIT_RST;
			lower_limit_q <= LOWER_LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_TANK_HEIGHT: tank_height_q <= pwdata[REG_W-1:0];
				REG_CYL_RADIUS:  cyl_radius_q  <= pwdata[REG_W-1:0];
				REG_UPPER_LIMIT: upper_limit_q <= pwdata[REG_W-1:0];
				REG_LOWER_LIMIT: lower_limit_q <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pump_nx   = pump_q;
		buzzer_nx = buzzer_q;
		if (rem_q < lower_limit_q)
			pump_nx = 1'b1;
		if (rem_q >= upper_limit_q) begin
			pump_nx   = 1'b0;
			buzzer_nx = 1'b1;
		end
		tick_nx  = tick_count_q + 1'b1;
		check    = (tick_nx >= FAULT_CHECK_TICKS);
		fault_nx = fault_q;
		if (check) begin
			if (pump_nx)
				fault_nx = flowing ? FAULT_NONE : FAULT_ON_DRY;
			else
				fault_nx = flowing ? FAULT_OFF_FLOW : FAULT_NONE;
			tick_nx = '0;
			if (fault_nx == FAULT_NONE || (rem_q < upper_limit_q && rem_q > lower_limit_q))
				buzzer_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		mul_en        = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		div_req.start = 1'b0;
		div_req.steps = FLOW_STEPS;
		div_req.num   = num_q;
		div_req.den   = prod_q[DIV_DEN_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && req == REQ_TICK)
					state_nx = ST_MEAS;
			end
			ST_MEAS: begin
				mul_en   = 1'b1;
				mul_a    = {4'b0, meas_num};
				mul_b    = MEAS_RECIP;
				state_nx = ST_RR;
			end
			ST_RR: begin
				mul_en   = 1'b1;
				mul_a    = {16'b0, cyl_radius_q};
				mul_b    = {16'b0, cyl_radius_q};
				state_nx = ST_RRH;
			end
			ST_RRH: begin
				mul_en   = 1'b1;
				mul_a    = prod_q[31:0];
				mul_b    = {16'b0, rem_q};
				state_nx = ST_VHI;
			end
			ST_VHI: begin
				mul_en   = 1'b1;
				mul_a    = {4'b0, prod_q[47:20]};
				mul_b    = PI_Q28;
				state_nx = ST_VLO;
			end
			ST_VLO: begin
				mul_en   = 1'b1;
				mul_a    = {12'b0, vlo_q};
				mul_b    = PI_Q28;
				state_nx = ST_VSUM;
			end
			ST_VSUM: begin
				state_nx = ST_FNUM;
			end
			ST_FNUM: begin
				mul_en   = 1'b1;
				mul_a    = {16'b0, pc_q};
				mul_b    = FLOW_SCALE;
				state_nx = ST_FDEN;
			end
			ST_FDEN: begin
				mul_en   = 1'b1;
				mul_a    = elapsed_q;
				mul_b    = FLOW_DIV;
				state_nx = ST_FDIV;
			end
			ST_FDIV: begin
				if (elapsed_q != '0) begin
					div_req.start = 1'b1;
					state_nx      = ST_FWAIT;
				end else begin
					state_nx = ST_DONE;
				end
			end
			ST_FWAIT: begin
				if (div_done)
					state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (commit)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	tlpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= 64'(mul_a) * 64'(mul_b);
		if (state_q == ST_RR) begin
			meas_q <= meas_div;
			rem_q  <= ({3'b0, tank_height_q} > meas_div) ?
				REG_W'({3'b0, tank_height_q} - meas_div) : '0;
		end
		if (state_q == ST_VHI)
			vlo_q <= prod_q[19:0];
		if (state_q == ST_VLO)
			a_q <= prod_q[57:0];
		if (state_q == ST_VSUM)
			vol_q <= vol_sum[58] ? '1 : vol_sum[57:32];
		if (state_q == ST_FDEN)
			num_q <= prod_q[DIV_NUM_W-1:0];
		if (state_q == ST_FDIV)
			flow_q <= '0;
		if (state_q == ST_FWAIT && div_done)
			flow_q <= (div_quo[DIV_NUM_W-1:FLOW_W] != '0) ? '1 : div_quo[FLOW_W-1:0];
		if (commit) begin
			out_pulse_q   <= echo_width_q;
			out_meas_q    <= meas_q;
			out_rem_q     <= rem_q;
			out_vol_q     <= vol_q;
			out_flow_q    <= flow_q;
			out_pump_q    <= pump_nx;
			out_buzzer_q  <= buzzer_nx;
			out_fault_q   <= fault_nx;
			out_checked_q <= check;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_start_q       <= '0;
			echo_width_q       <= '0;
			pulse_count_q      <= '0;
			pc_q               <= '0;
			interval_start_q   <= '0;
			elapsed_q          <= '0;
			interval_started_q <= 1'b0;
			pump_q             <= 1'b1;
			buzzer_q           <= 1'b0;
			tick_count_q       <= '0;
			fault_q            <= FAULT_NONE;
			out_valid_q        <= 1'b0;
		end else begin
			if (in_xfer) begin
				case (req)
					REQ_ECHO_RISE: echo_start_q <= s_tdata;
					REQ_ECHO_FALL: echo_width_q <= (echo_d[31:16] != '0) ? '1 : echo_d[15:0];
					REQ_PULSE: begin
						if (pulse_count_q != '1)
							pulse_count_q <= pulse_count_q + 1'b1;
					end
					REQ_TICK: begin
						elapsed_q          <= interval_started_q ? s_tdata - interval_start_q : '0;
						pc_q               <= pulse_count_q;
						pulse_count_q      <= '0;
						interval_start_q   <= s_tdata;
						interval_started_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				out_valid_q <= 1'b0;
			if (commit) begin
				pump_q       <= pump_nx;
				buzzer_q     <= buzzer_nx;
				tick_count_q <= tick_nx;
				fault_q      <= fault_nx;
				out_valid_q  <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_checked_q, out_fault_q, out_buzzer_q, out_pump_q,
		out_flow_q, out_vol_q, out_rem_q, out_meas_q, out_pulse_q};

endmodule
`default_nettype wire

@@ sv/tlpm_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module tlpm_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tlpm_pkg::div_req_t             req,
	output logic                                done,
	output logic [tlpm_pkg::DIV_NUM_W-1:0]      quo
);
	import tlpm_pkg::*;

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

@@ sv/tlpm_checker.sv @@
// Port-level checks for the tank level and pump monitor, bound to the top level.
`default_nettype none
module tlpm_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	input  wire logic                               s_tready,
	input  wire logic [1:0]                         s_tuser,
	input  wire logic                               m_tvalid,
	input  wire logic                               m_tready,
	input  wire logic [tlpm_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import tlpm_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// drop ready after a tick transfer
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == REQ_TICK |=> !s_tready)
		else $error("ready held after tick");

	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[104:103] != FAULT_RSVD)
		else $error("undefined fault code");

	a_clear_buzzer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[105] && m_tdata[104:103] == FAULT_NONE |-> !m_tdata[102])
		else $error("buzzer on after clean fault check");

endmodule

bind tank_level_pump_monitor tlpm_checker u_tlpm_checker (.*);
`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for the tank level and pump monitor: event stimulus, tick report prediction and checks.
`default_nettype none
module tb_top;
	import tlpm_pkg::*;

	typedef struct {
		logic [15:0] width;
		logic [18:0] meas;
		logic [15:0] remaining;
		logic [25:0] volume;
		logic [23:0] flow;
		logic        pump;
		logic        buzzer;
		fault_t      fault;
		logic        checked;
	} tank_report_t;

	class tank_report_board;
		localparam longint unsigned PI_FIX     = 64'd843314857;
		localparam longint unsigned VOLUME_TOP = 64'd67108863;
		localparam longint unsigned FLOW_TOP   = 64'd16777215;
		localparam int unsigned     CHECK_EVERY = 10;

		logic [15:0] tank_height, cyl_radius, upper_limit, lower_limit;
		logic [31:0] echo_start, interval_start;
		logic [15:0] echo_width, pulse_count;
		logic        interval_started, pump_running, buzzer_active;
		logic [7:0]  tick_count;
		fault_t      fault_state;
		tank_report_t expected_reports[$];
		int unsigned mismatches;

		function new();
			tank_height = 16'd21760;
			cyl_radius = 16'd4608;
			upper_limit = 16'd21760;
			lower_limit = 16'd4352;
			echo_start = '0;
			interval_start = '0;
			echo_width = '0;
			pulse_count = '0;
			interval_started = 1'b0;
			pump_running = 1'b1;
			buzzer_active = 1'b0;
			tick_count = '0;
			fault_state = FAULT_NONE;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [15:0] v);
			case (idx)
				REG_TANK_HEIGHT: tank_height = v;
				REG_CYL_RADIUS:  cyl_radius = v;
				REG_UPPER_LIMIT: upper_limit = v;
				REG_LOWER_LIMIT: lower_limit = v;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_reports.size();
		endfunction

		function void take_event(req_t kind, logic [31:0] t);
			logic [31:0] span, elapsed;
			longint unsigned meas, rem, vol_raw, hi, lo, vol, flow;
			logic flowing;
			tank_report_t r;
			case (kind)
				REQ_ECHO_RISE: echo_start = t;
				REQ_ECHO_FALL: begin
					span = t - echo_start;
					echo_width = (span > 32'hFFFF) ? 16'hFFFF : span[15:0];
				end
				REQ_PULSE: if (pulse_count != 16'hFFFF) pulse_count = pulse_count + 16'd1;
				REQ_TICK: begin
					meas = (64'(echo_width) * 64'd2560 + 64'd291) / 64'd582;
					rem = (64'(tank_height) > meas) ? 64'(tank_height) - meas : 64'd0;
					vol_raw = 64'(cyl_radius) * 64'(cyl_radius) * rem;
					hi = (vol_raw >> 20) * PI_FIX;
					lo = (vol_raw & 64'hFFFFF) * PI_FIX;
					vol = (hi + 64'h8000_0000 + (lo >> 20)) >> 32;
					if (vol > VOLUME_TOP) vol = VOLUME_TOP;
					if (!interval_started) begin
						interval_start = t;
						interval_started = 1'b1;
					end
					elapsed = t - interval_start;
					if (elapsed != 0) begin
						flow = (64'(pulse_count) * 64'd2000000000) / (64'(elapsed) * 64'd15);
						if (flow > FLOW_TOP) flow = FLOW_TOP;
					end else begin
						flow = 0;
					end
					flowing = (pulse_count != 0) && (elapsed != 0);
					pulse_count = '0;
					interval_start = t;
					if (rem < 64'(lower_limit)) pump_running = 1'b1;
					if (rem >= 64'(upper_limit)) begin
						pump_running = 1'b0;
						buzzer_active = 1'b1;
					end
					tick_count = tick_count + 8'd1;
					r.checked = 1'b0;
					if (tick_count >= CHECK_EVERY) begin
						if (pump_running) fault_state = flowing ? FAULT_NONE : FAULT_ON_DRY;
						else fault_state = flowing ? FAULT_OFF_FLOW : FAULT_NONE;
						tick_count = '0;
						r.checked = 1'b1;
						if (fault_state == FAULT_NONE ||
						    (rem < 64'(upper_limit) && rem > 64'(lower_limit)))
							buzzer_active = 1'b0;
					end
					r.width = echo_width;
					r.meas = meas[18:0];
					r.remaining = rem[15:0];
					r.volume = vol[25:0];
					r.flow = flow[23:0];
					r.pump = pump_running;
					r.buzzer = buzzer_active;
					r.fault = fault_state;
					expected_reports.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void compare(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("report %s mismatch: expected %0d, actual %0d", name, want, got);
			end
		endfunction

		function void check_report(logic [OUT_DATA_W-1:0] d);
			tank_report_t want;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("report with nothing expected: actual %h", d);
				return;
			end
			want = expected_reports.pop_front();
			compare("pulse_width_us", want.width, d[15:0]);
			compare("surface_depth", want.meas, d[34:16]);
			compare("height_remaining", want.remaining, d[50:35]);
			compare("volume_ml", want.volume, d[76:51]);
			compare("flow_rate", want.flow, d[100:77]);
			compare("pump_on", want.pump, d[101]);
			compare("buzzer_on", want.buzzer, d[102]);
			compare("fault_code", want.fault, d[104:103]);
			compare("fault_checked", want.checked, d[105]);
		endfunction
	endclass

	localparam int HOLD_CYCLES   = 600;
	localparam int SETTLE_CYCLES = 120;
	localparam int TAIL_CYCLES   = 200;
	localparam int RUN_LIMIT     = 5000000;

	logic                  clk;
	logic                  arst_n;
	logic                  psel, penable, pwrite;
	logic [APB_AW-1:0]     paddr;
	logic [APB_DW-1:0]     pwdata;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;
	logic                  s_tvalid, s_tready;
	logic [31:0]           s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid, m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	tank_report_board sb;
	logic        idle_on;
	logic        hold_off_req;
	logic [31:0] now_us;
	int unsigned items_sent;

	tank_level_pump_monitor i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#RUN_LIMIT;
		$display("tb_top failed");
		$finish;
	end

	task automatic send_event(input req_t kind, input logic [31:0] t);
		int gap;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= t;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.take_event(kind, t);
		items_sent++;
	endtask

	task automatic settle();
		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0000, v};
		@(negedge clk) penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_tank(input logic [15:0] h, input logic [15:0] r,
	                        input logic [15:0] up, input logic [15:0] lo);
		write_reg(REG_TANK_HEIGHT, h);
		write_reg(REG_CYL_RADIUS, r);
		write_reg(REG_UPPER_LIMIT, up);
		write_reg(REG_LOWER_LIMIT, lo);
	endtask

	// one measurement second: echo, a few flow pulses, then the tick
	task automatic one_second();
		logic [31:0] w, step;
		int n;
		if ($urandom_range(0, 9) == 0) w = 0;
		else if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 70000);
		else w = $urandom_range(1, 6000);
		if ($urandom_range(0, 19) != 0) send_event(REQ_ECHO_RISE, now_us);
		send_event(REQ_ECHO_FALL, now_us + w);
		n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		for (int i = 0; i < n; i++) send_event(REQ_PULSE, now_us + w + 32'(i * 1000));
		case ($urandom_range(0, 19))
			0:       step = 0;
			1, 2:    step = $urandom_range(1, 2000);
			3:       step = $urandom;
			default: step = 32'd999500 + $urandom_range(0, 1000);
		endcase
		now_us = now_us + step;
		send_event(REQ_TICK, now_us);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned first;
		first = items_sent;
		while (items_sent - first < count) begin
			if ($urandom_range(0, 4) == 0) send_event(req_t'($urandom_range(0, 3)), $urandom);
			else one_second();
		end
	endtask

	task automatic run_phase(input int unsigned count);
		run_random(count / 2);
		settle();
		run_random(count - count / 2);
		settle();
	endtask

	initial begin : sink
		int gap;
		m_tready = 1'b0;
		forever begin
			if (hold_off_req) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			gap = idle_on ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			sb.check_report(m_tdata);
		end
	end

	initial begin : stimulus
		logic [15:0] h, up, lo;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_ECHO_RISE;
		idle_on = 1'b1;
		hold_off_req = 1'b0;
		items_sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		repeat (5) @(posedge clk);

		// first tick, then a fall with no rise, a wrapped echo, a zero and a saturated width
		send_event(REQ_TICK, 32'd100);
		send_event(REQ_ECHO_FALL, 32'd50);
		send_event(REQ_ECHO_RISE, 32'hFFFF_FFF0);
		send_event(REQ_ECHO_FALL, 32'h0000_0010);
		send_event(REQ_ECHO_RISE, 32'd1000);
		send_event(REQ_ECHO_FALL, 32'd1000);
		send_event(REQ_ECHO_RISE, 32'h0000_0000);
		send_event(REQ_ECHO_FALL, 32'hFFFF_FFFF);
		send_event(REQ_TICK, 32'd1000100);
		// pulses with zero elapsed time, then one pulse over the longest interval
		repeat (3) send_event(REQ_PULSE, 32'd1000100);
		send_event(REQ_TICK, 32'd1000100);
		send_event(REQ_PULSE, 32'd1000200);
		send_event(REQ_TICK, 32'd1000099);
		send_event(REQ_ECHO_RISE, 32'd5);
		send_event(REQ_ECHO_FALL, 32'd1005);
		send_event(REQ_TICK, 32'd2000099);
		for (int i = 0; i < 5; i++) send_event(REQ_TICK, 32'd3000099 + 32'(i) * 32'd1000000);
		settle();

		now_us = $urandom;
		run_phase(100);

		set_tank(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
		run_phase(100);

		idle_on = 1'b0;
		set_tank(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		run_phase(60);
		idle_on = 1'b1;

		h = 16'($urandom_range(8000, 65535));
		up = 16'($urandom_range(h / 2, h));
		lo = 16'($urandom_range(0, up));
		set_tank(h, 16'($urandom_range(0, 65535)), up, lo);
		run_phase(100);

		// lower limit above upper limit: both pump rules can hold at once
		h = 16'($urandom_range(8000, 30000));
		lo = 16'($urandom_range(h / 2, h));
		up = 16'($urandom_range(0, lo));
		set_tank(h, 16'($urandom_range(0, 65535)), up, lo);
		run_phase(100);

		// a few pulses, then a tick one microsecond later
		idle_on = 1'b0;
		set_tank(16'd21760, 16'd4608, 16'd21760, 16'd4352);
		send_event(REQ_TICK, now_us);
		repeat (5) send_event(REQ_PULSE, now_us);
		send_event(REQ_TICK, now_us + 32'd1);
		now_us = now_us + 32'd1;
		settle();
		idle_on = 1'b1;

		// hold the report side off while events keep arriving
		set_tank(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		hold_off_req = 1'b1;
		run_phase(100);

		set_tank(16'd30000, 16'd6000, 16'd20000, 16'd8000);
		run_phase(80);

		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
